/* design/lbbm_pkg.sv */
// ----------------------------------------------------------------------------
// lbbm_pkg
// Shared constants, operation and status codes, and memory access types of
// the linked block buffer manager.
// ----------------------------------------------------------------------------
package lbbm_pkg;

  localparam int unsigned NUM_BLOCKS = 256;

  localparam logic [8:0]  NULL_LINK       = 9'd256;
  localparam logic [8:0]  POOL_MAX        = 9'd256;
  localparam logic [12:0] MAX_BLOCK_BYTES = 13'd4096;
  localparam logic [20:0] BYTES_MAX       = 21'h1FFFFF;

  localparam logic [12:0] BLOCK_BYTES_RST   = 13'd64;
  localparam logic [8:0]  BLOCKS_IN_USE_RST = 9'd256;

  // operation codes
  localparam logic [2:0] OP_INIT  = 3'd0;
  localparam logic [2:0] OP_ALLOC = 3'd1;
  localparam logic [2:0] OP_FREE  = 3'd2;
  localparam logic [2:0] OP_LINK  = 3'd3;
  localparam logic [2:0] OP_MARK  = 3'd4;
  localparam logic [2:0] OP_QUERY = 3'd5;
  localparam logic [2:0] OP_PUSH  = 3'd6;
  localparam logic [2:0] OP_POP   = 3'd7;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOBLK  = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADIDX = 2'd3;

  // register indexes
  localparam logic REG_BLOCK_BYTES   = 1'b0;
  localparam logic REG_BLOCKS_IN_USE = 1'b1;

  typedef struct packed {
    logic [8:0] nxt;
    logic       mark;
  } link_ent_t;

  typedef struct packed {
    logic      en;
    logic [7:0] addr;
    link_ent_t data;
  } link_wr_t;

  typedef struct packed {
    logic        en;
    logic [7:0]  addr;
    logic [12:0] data;
  } size_wr_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
  } mem_rd_t;

endpackage

/* design/lbbm_if.sv */
// ----------------------------------------------------------------------------
// lbbm channel interfaces
// Request and response channels, valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface lbbm_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [7:0]  block;
  logic [7:0]  other_block;
  logic [20:0] amount;

  modport source (output valid, operation, block, other_block, amount, input ready);
  modport sink   (input valid, operation, block, other_block, amount, output ready);
endinterface

interface lbbm_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  result_block;
  logic [20:0] used_bytes;
  logic [20:0] chain_bytes;
  logic [8:0]  free_now;
  logic [8:0]  free_min;

  modport source (output valid, status, result_block, used_bytes, chain_bytes,
                  free_now, free_min, input ready);
  modport sink   (input valid, status, result_block, used_bytes, chain_bytes,
                  free_now, free_min, output ready);
endinterface

/* design/lbbm_cfg.sv */
// ----------------------------------------------------------------------------
// lbbm_cfg
// APB-style register file: block size and number of blocks carved at init.
// ----------------------------------------------------------------------------
module lbbm_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [12:0] block_bytes_o,
  output logic [8:0]  blocks_in_use_o
);

  logic [12:0] bb_q, bb_d;
  logic [8:0]  biu_q, biu_d;
  logic        wr;

  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    bb_d  = bb_q;
    biu_d = biu_q;
    if (wr) begin
      if (paddr[2] == lbbm_pkg::REG_BLOCKS_IN_USE) begin
        biu_d = pwdata[8:0];
      end else begin
        bb_d = pwdata[12:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bb_q  <= lbbm_pkg::BLOCK_BYTES_RST;
      biu_q <= lbbm_pkg::BLOCKS_IN_USE_RST;
    end else begin
      bb_q  <= bb_d;
      biu_q <= biu_d;
    end
  end

  always_comb begin
    if (paddr[2] == lbbm_pkg::REG_BLOCKS_IN_USE) begin
      prdata = {23'd0, biu_q};
    end else begin
      prdata = {19'd0, bb_q};
    end
  end

  assign block_bytes_o   = bb_q;
  assign blocks_in_use_o = biu_q;

endmodule

/* design/lbbm_link_mem.sv */
// ----------------------------------------------------------------------------
// lbbm_link_mem
// Next-link and last-mark memory with one valid bit per entry. An entry not
// written since init reads as the carved free list: i+1 if below the pool.
// ----------------------------------------------------------------------------
module lbbm_link_mem (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                init_i,
  input  logic [8:0]          pool_i,
  input  lbbm_pkg::mem_rd_t   rd_i,
  input  lbbm_pkg::link_wr_t  wr_i,
  output lbbm_pkg::link_ent_t ent_o
);

  lbbm_pkg::link_ent_t mem [lbbm_pkg::NUM_BLOCKS];
  lbbm_pkg::link_ent_t rdata_q;
  logic [lbbm_pkg::NUM_BLOCKS-1:0] vld_q;
  logic       rvld_q;
  logic [7:0] raddr_q;
  logic [8:0] dflt;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
      raddr_q <= rd_i.addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (init_i) begin
        vld_q <= '0;
      end else if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        rvld_q <= vld_q[rd_i.addr];
      end
    end
  end

  // carved order of an untouched entry
  assign dflt = (({1'b0, raddr_q} + 9'd1) < pool_i) ? ({1'b0, raddr_q} + 9'd1)
                                                    : lbbm_pkg::NULL_LINK;

  always_comb begin
    if (rvld_q) begin
      ent_o = rdata_q;
    end else begin
      ent_o.nxt  = dflt;
      ent_o.mark = 1'b0;
    end
  end

endmodule

/* design/lbbm_size_mem.sv */
// ----------------------------------------------------------------------------
// lbbm_size_mem
// Used-size memory, one word per block, registered read.
// ----------------------------------------------------------------------------
module lbbm_size_mem (
  input  logic               clk_i,
  input  lbbm_pkg::mem_rd_t  rd_i,
  input  lbbm_pkg::size_wr_t wr_i,
  output logic [12:0]        rdata_o
);

  logic [12:0] mem [lbbm_pkg::NUM_BLOCKS];
  logic [12:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/lbbm_ctrl.sv */
// ----------------------------------------------------------------------------
// lbbm_ctrl
// Operation sequencer: chain walks, allocation, free list and chain FIFO
// bookkeeping, and the response register.
// ----------------------------------------------------------------------------
module lbbm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  lbbm_req_if.sink             req,
  lbbm_rsp_if.source           rsp,
  input  logic [12:0]          block_bytes_i,
  input  logic [8:0]           blocks_in_use_i,
  input  lbbm_pkg::link_ent_t  link_ent_i,
  input  logic [12:0]          size_rd_i,
  output lbbm_pkg::mem_rd_t    mem_rd_o,
  output lbbm_pkg::link_wr_t   link_wr_o,
  output lbbm_pkg::size_wr_t   size_wr_o,
  output logic                 init_o,
  output logic [8:0]           pool_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ARD  = 4'd1;
  localparam logic [3:0] S_ACHK = 4'd2;
  localparam logic [3:0] S_TRD  = 4'd3;
  localparam logic [3:0] S_TDAT = 4'd4;
  localparam logic [3:0] S_TLNK = 4'd5;
  localparam logic [3:0] S_WRD  = 4'd6;
  localparam logic [3:0] S_WALK = 4'd7;
  localparam logic [3:0] S_PRD  = 4'd8;
  localparam logic [3:0] S_PWR  = 4'd9;
  localparam logic [3:0] S_LRD  = 4'd10;
  localparam logic [3:0] S_LWR  = 4'd11;
  localparam logic [3:0] S_MRD  = 4'd12;
  localparam logic [3:0] S_MWR  = 4'd13;
  localparam logic [3:0] S_RESP = 4'd14;

  function automatic logic [21:0] sat_add(input logic [21:0] a, input logic [12:0] b);
    logic [21:0] s;
    s = a + {9'd0, b};
    if (s > {1'b0, lbbm_pkg::BYTES_MAX}) begin
      s = {1'b0, lbbm_pkg::BYTES_MAX};
    end
    return s;
  endfunction

  logic [3:0]  state_q, state_d;
  logic [2:0]  op_q, op_d;
  logic [7:0]  blk_q, blk_d, oth_q, oth_d;
  logic [20:0] amt_q, amt_d;
  logic [7:0]  node_q, node_d, prev_q, prev_d;
  logic [8:0]  cnt_q, cnt_d;
  logic [21:0] acc_q, acc_d, sum_q, sum_d;
  logic        first_q, first_d;
  logic [1:0]  st_q, st_d;
  logic [7:0]  res_q, res_d;
  logic [8:0]  fh_q, fh_d, fc_q, fc_d, lw_q, lw_d, qh_q, qh_d, qt_q, qt_d;
  logic [8:0]  pool_q, pool_d;
  logic        ov_q, ov_d;
  logic [1:0]  ost_q, ost_d;
  logic [7:0]  ores_q, ores_d;
  logic [20:0] oused_q, oused_d, ochain_q, ochain_d;
  logic [8:0]  ofn_q, ofn_d, ofm_q, ofm_d;

  logic [12:0] bb;
  logic        bad, stop, stop_mark;
  logic [8:0]  n_init, fc_dec;
  logic [9:0]  fc_sum;
  logic [8:0]  nx;
  logic        mk;

  assign nx = link_ent_i.nxt;
  assign mk = link_ent_i.mark;

  always_comb begin
    if (block_bytes_i == 13'd0) begin
      bb = 13'd1;
    end else if (block_bytes_i > lbbm_pkg::MAX_BLOCK_BYTES) begin
      bb = lbbm_pkg::MAX_BLOCK_BYTES;
    end else begin
      bb = block_bytes_i;
    end
  end

  assign bad = ((req.operation >= lbbm_pkg::OP_FREE) && (req.operation <= lbbm_pkg::OP_PUSH)
                && ({1'b0, req.block} >= pool_q))
               || ((req.operation == lbbm_pkg::OP_LINK) && ({1'b0, req.other_block} >= pool_q));

  assign n_init    = (blocks_in_use_i > lbbm_pkg::POOL_MAX) ? lbbm_pkg::POOL_MAX
                                                           : blocks_in_use_i;
  assign fc_dec    = (fc_q != 9'd0) ? (fc_q - 9'd1) : 9'd0;
  assign fc_sum    = {1'b0, fc_q} + {1'b0, cnt_q};
  assign stop_mark = (op_q == lbbm_pkg::OP_QUERY) || (op_q == lbbm_pkg::OP_POP);
  assign stop      = (cnt_q == lbbm_pkg::POOL_MAX) || (stop_mark && mk) || nx[8];

  assign req.ready = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    op_d = op_q; blk_d = blk_q; oth_d = oth_q; amt_d = amt_q;
    node_d = node_q; prev_d = prev_q; cnt_d = cnt_q;
    acc_d = acc_q; sum_d = sum_q; first_d = first_q;
    st_d = st_q; res_d = res_q;
    fh_d = fh_q; fc_d = fc_q; lw_d = lw_q; qh_d = qh_q; qt_d = qt_q; pool_d = pool_q;
    ov_d = ov_q; ost_d = ost_q; ores_d = ores_q; oused_d = oused_q; ochain_d = ochain_q;
    ofn_d = ofn_q; ofm_d = ofm_q;
    mem_rd_o  = '0;
    link_wr_o = '0;
    size_wr_o = '0;
    init_o    = 1'b0;

    if (ov_q && rsp.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          op_d  = req.operation;
          blk_d = req.block;
          oth_d = req.other_block;
          amt_d = req.amount;
          st_d  = lbbm_pkg::ST_OK;
          res_d = 8'd0;
          sum_d = '0;
          acc_d = '0;
          node_d = req.block;
          if (bad) begin
            st_d    = lbbm_pkg::ST_BADIDX;
            state_d = S_RESP;
          end else begin
            case (req.operation)
              lbbm_pkg::OP_INIT: begin
                init_o  = 1'b1;
                pool_d  = n_init;
                fh_d    = (n_init != 9'd0) ? 9'd0 : lbbm_pkg::NULL_LINK;
                fc_d    = n_init;
                lw_d    = n_init;
                qh_d    = lbbm_pkg::NULL_LINK;
                qt_d    = lbbm_pkg::NULL_LINK;
                state_d = S_RESP;
              end
              lbbm_pkg::OP_ALLOC: begin
                if ((fc_q == 9'd0) || fh_q[8]) begin
                  st_d    = lbbm_pkg::ST_NOBLK;
                  lw_d    = 9'd0;
                  state_d = S_RESP;
                end else begin
                  node_d  = fh_q[7:0];
                  cnt_d   = 9'd1;
                  acc_d   = {9'd0, bb};
                  state_d = S_ARD;
                end
              end
              lbbm_pkg::OP_MARK: begin
                state_d = S_MRD;
              end
              lbbm_pkg::OP_PUSH: begin
                if (qh_q[8]) begin
                  qh_d    = {1'b0, req.block};
                  state_d = S_WRD;
                end else if (!qt_q[8]) begin
                  state_d = S_PRD;
                end else begin
                  state_d = S_WRD;
                end
              end
              lbbm_pkg::OP_POP: begin
                if (qh_q[8]) begin
                  st_d    = lbbm_pkg::ST_EMPTY;
                  state_d = S_RESP;
                end else begin
                  res_d   = qh_q[7:0];
                  node_d  = qh_q[7:0];
                  state_d = S_WRD;
                end
              end
              default: begin
                state_d = S_WRD;
              end
            endcase
          end
        end
      end

      // allocation check: free list must reach the needed block count
      S_ARD: begin
        mem_rd_o.en   = 1'b1;
        mem_rd_o.addr = node_q;
        state_d       = S_ACHK;
      end

      S_ACHK: begin
        if (acc_q >= {1'b0, amt_q}) begin
          if (cnt_q <= fc_q) begin
            sum_d   = '0;
            first_d = 1'b1;
            state_d = S_TRD;
          end else begin
            st_d    = lbbm_pkg::ST_NOBLK;
            lw_d    = 9'd0;
            state_d = S_RESP;
          end
        end else if ((cnt_q >= fc_q) || nx[8]) begin
          st_d    = lbbm_pkg::ST_NOBLK;
          lw_d    = 9'd0;
          state_d = S_RESP;
        end else begin
          mem_rd_o.en   = 1'b1;
          mem_rd_o.addr = nx[7:0];
          node_d        = nx[7:0];
          cnt_d         = cnt_q + 9'd1;
          acc_d         = sat_add(acc_q, bb);
        end
      end

      S_TRD: begin
        mem_rd_o.en   = 1'b1;
        mem_rd_o.addr = fh_q[7:0];
        node_d        = fh_q[7:0];
        state_d       = S_TDAT;
      end

      S_TDAT: begin
        fh_d                = nx;
        link_wr_o.en        = 1'b1;
        link_wr_o.addr      = node_q;
        link_wr_o.data.nxt  = lbbm_pkg::NULL_LINK;
        link_wr_o.data.mark = 1'b1;
        size_wr_o.en        = 1'b1;
        size_wr_o.addr      = node_q;
        size_wr_o.data      = bb;
        fc_d                = fc_dec;
        lw_d                = (fc_dec < lw_q) ? fc_dec : lw_q;
        sum_d               = sat_add(sum_q, bb);
        if (first_q) begin
          res_d = node_q;
        end
        state_d = S_TLNK;
      end

      S_TLNK: begin
        if (!first_q) begin
          link_wr_o.en        = 1'b1;
          link_wr_o.addr      = prev_q;
          link_wr_o.data.nxt  = {1'b0, node_q};
          link_wr_o.data.mark = 1'b0;
        end
        first_d = 1'b0;
        prev_d  = node_q;
        if ((sum_q >= {1'b0, amt_q}) || fh_q[8]) begin
          state_d = S_RESP;
        end else begin
          state_d = S_TRD;
        end
      end

      S_WRD: begin
        mem_rd_o.en   = 1'b1;
        mem_rd_o.addr = node_q;
        cnt_d         = 9'd1;
        acc_d         = '0;
        sum_d         = '0;
        state_d       = S_WALK;
      end

      // one chain entry per cycle
      S_WALK: begin
        sum_d = sat_add(sum_q, size_rd_i);
        acc_d = sat_add(acc_q, bb);
        if (!stop) begin
          mem_rd_o.en   = 1'b1;
          mem_rd_o.addr = nx[7:0];
          node_d        = nx[7:0];
          cnt_d         = cnt_q + 9'd1;
        end else begin
          state_d = S_RESP;
          case (op_q)
            lbbm_pkg::OP_FREE: begin
              link_wr_o.en        = 1'b1;
              link_wr_o.addr      = node_q;
              link_wr_o.data.nxt  = fh_q;
              link_wr_o.data.mark = mk;
              fh_d = {1'b0, blk_q};
              fc_d = (fc_sum > {1'b0, lbbm_pkg::POOL_MAX}) ? lbbm_pkg::POOL_MAX : fc_sum[8:0];
            end
            lbbm_pkg::OP_LINK: begin
              link_wr_o.en        = 1'b1;
              link_wr_o.addr      = node_q;
              link_wr_o.data.nxt  = {1'b0, oth_q};
              link_wr_o.data.mark = 1'b0;
              state_d             = S_LRD;
            end
            lbbm_pkg::OP_PUSH: begin
              qt_d = {1'b0, node_q};
            end
            lbbm_pkg::OP_POP: begin
              link_wr_o.en        = 1'b1;
              link_wr_o.addr      = node_q;
              link_wr_o.data.nxt  = lbbm_pkg::NULL_LINK;
              link_wr_o.data.mark = mk;
              if (nx[8]) begin
                qh_d = lbbm_pkg::NULL_LINK;
                qt_d = lbbm_pkg::NULL_LINK;
              end else begin
                qh_d = nx;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // push onto a non-empty FIFO: append behind the current tail
      S_PRD: begin
        mem_rd_o.en   = 1'b1;
        mem_rd_o.addr = qt_q[7:0];
        state_d       = S_PWR;
      end

      S_PWR: begin
        link_wr_o.en        = 1'b1;
        link_wr_o.addr      = qt_q[7:0];
        link_wr_o.data.nxt  = {1'b0, blk_q};
        link_wr_o.data.mark = mk;
        node_d              = blk_q;
        state_d             = S_WRD;
      end

      S_LRD: begin
        mem_rd_o.en   = 1'b1;
        mem_rd_o.addr = oth_q;
        state_d       = S_LWR;
      end

      S_LWR: begin
        link_wr_o.en        = 1'b1;
        link_wr_o.addr      = oth_q;
        link_wr_o.data.nxt  = nx;
        link_wr_o.data.mark = 1'b1;
        state_d             = S_RESP;
      end

      S_MRD: begin
        mem_rd_o.en   = 1'b1;
        mem_rd_o.addr = blk_q;
        state_d       = S_MWR;
      end

      S_MWR: begin
        if (amt_q < {8'd0, size_rd_i}) begin
          size_wr_o.en   = 1'b1;
          size_wr_o.addr = blk_q;
          size_wr_o.data = amt_q[12:0];
        end
        state_d = S_RESP;
      end

      S_RESP: begin
        if (!ov_q || rsp.ready) begin
          ov_d   = 1'b1;
          ost_d  = st_q;
          ores_d = res_q;
          if (op_q == lbbm_pkg::OP_QUERY && st_q == lbbm_pkg::ST_OK) begin
            oused_d  = sum_q[20:0];
            ochain_d = acc_q[20:0];
          end else begin
            oused_d  = 21'd0;
            ochain_d = 21'd0;
          end
          ofn_d   = fc_q;
          ofm_d   = lw_q;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fh_q    <= lbbm_pkg::NULL_LINK;
      fc_q    <= 9'd0;
      lw_q    <= 9'd0;
      qh_q    <= lbbm_pkg::NULL_LINK;
      qt_q    <= lbbm_pkg::NULL_LINK;
      pool_q  <= 9'd0;
      ov_q    <= 1'b0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fh_q    <= fh_d;
      fc_q    <= fc_d;
      lw_q    <= lw_d;
      qh_q    <= qh_d;
      qt_q    <= qt_d;
      pool_q  <= pool_d;
      ov_q    <= ov_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    blk_q    <= blk_d;
    oth_q    <= oth_d;
    amt_q    <= amt_d;
    node_q   <= node_d;
    prev_q   <= prev_d;
    cnt_q    <= cnt_d;
    acc_q    <= acc_d;
    sum_q    <= sum_d;
    st_q     <= st_d;
    res_q    <= res_d;
    ost_q    <= ost_d;
    ores_q   <= ores_d;
    oused_q  <= oused_d;
    ochain_q <= ochain_d;
    ofn_q    <= ofn_d;
    ofm_q    <= ofm_d;
  end

  assign pool_o           = pool_q;
  assign rsp.valid        = ov_q;
  assign rsp.status       = ost_q;
  assign rsp.result_block = ores_q;
  assign rsp.used_bytes   = oused_q;
  assign rsp.chain_bytes  = ochain_q;
  assign rsp.free_now     = ofn_q;
  assign rsp.free_min     = ofm_q;

endmodule

/* design/linked_block_buffer_manager_unit.sv */
// ----------------------------------------------------------------------------
// linked_block_buffer_manager_unit
// Pool of 256 fixed blocks with chained buffers, free list and chain FIFO.
// ----------------------------------------------------------------------------
// One request is worked on at a time; its response goes to an output
// register, so the next request is taken while a response waits. The link
// table and the used sizes live in two memories with a shared, registered
// read port, which sets the pace. Init, mark, a bad index and pop on an
// empty FIFO walk no chain; free, query, push and pop read the chain block
// by block (link then reads and rewrites the other block, push onto a
// non-empty FIFO first reads and rewrites the tail); allocate reads the free
// list block by block, then passes S_TRD, S_TDAT and S_TLNK per block taken.
// Init needs no clearing pass: per-entry valid bits are cleared at once and
// an untouched entry reads as its carved free-list link.
module linked_block_buffer_manager_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  lbbm_req_if.sink    req_i,
  lbbm_rsp_if.source  rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [12:0]         block_bytes;
  logic [8:0]          blocks_in_use;
  lbbm_pkg::link_ent_t link_ent;
  logic [12:0]         size_rd;
  lbbm_pkg::mem_rd_t   mem_rd;
  lbbm_pkg::link_wr_t  link_wr;
  lbbm_pkg::size_wr_t  size_wr;
  logic                init;
  logic [8:0]          pool;

  lbbm_cfg u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .block_bytes_o   (block_bytes),
    .blocks_in_use_o (blocks_in_use)
  );

  lbbm_link_mem u_link_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .init_i (init),
    .pool_i (pool),
    .rd_i   (mem_rd),
    .wr_i   (link_wr),
    .ent_o  (link_ent)
  );

  lbbm_size_mem u_size_mem (
    .clk_i   (clk_i),
    .rd_i    (mem_rd),
    .wr_i    (size_wr),
    .rdata_o (size_rd)
  );

  lbbm_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req             (req_i),
    .rsp             (rsp_o),
    .block_bytes_i   (block_bytes),
    .blocks_in_use_i (blocks_in_use),
    .link_ent_i      (link_ent),
    .size_rd_i       (size_rd),
    .mem_rd_o        (mem_rd),
    .link_wr_o       (link_wr),
    .size_wr_o       (size_wr),
    .init_o          (init),
    .pool_o          (pool)
  );

  // a link write never collides with a read of the same entry
  a_no_rw_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (link_wr.en && mem_rd.en) |-> (link_wr.addr != mem_rd.addr))
    else $error("link read and write to the same entry");

  // no memory writes while waiting for a request
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> (!link_wr.en && !size_wr.en))
    else $error("memory write while idle");

  // low-water count never above the current free count
  a_low_water: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.free_min <= rsp_o.free_now))
    else $error("free_min above free_now");

endmodule

/* tb/lbbm_tb_if.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lbbm_tb_if
// APB-style register port bundle used by the testbench to drive the block's
// configuration registers.
// ----------------------------------------------------------------------------
interface lbbm_apb_if;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  modport source (output psel, penable, pwrite, paddr, pwdata, input prdata, pready);
  modport sink   (input psel, penable, pwrite, paddr, pwdata, output prdata, pready);
endinterface

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the linked block buffer manager against a cycle-free model of the
// block pool, free list and chain FIFO kept inside the bench. Requests are
// sent with random gaps, responses drained with random stalls, and each
// response is compared field by field with the predicted one.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  block;
    logic [7:0]  other_block;
    logic [20:0] amount;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  result_block;
    logic [20:0] used_bytes;
    logic [20:0] chain_bytes;
    logic [8:0]  free_now;
    logic [8:0]  free_min;
  } rsp_t;

  logic clk_i;
  logic rst_ni;

  lbbm_req_if req ();
  lbbm_rsp_if rsp ();
  lbbm_apb_if apb ();

  linked_block_buffer_manager_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rsp_o   (rsp),
    .psel    (apb.psel),
    .penable (apb.penable),
    .pwrite  (apb.pwrite),
    .paddr   (apb.paddr),
    .pwdata  (apb.pwdata),
    .prdata  (apb.prdata),
    .pready  (apb.pready)
  );

  // pool model
  logic [8:0]  nxt_tbl [lbbm_pkg::NUM_BLOCKS];
  bit          last_tbl [lbbm_pkg::NUM_BLOCKS];
  logic [12:0] size_tbl [lbbm_pkg::NUM_BLOCKS];
  bit          size_known [lbbm_pkg::NUM_BLOCKS];
  logic [8:0]  free_head, free_cnt, low_water, fifo_head, fifo_tail, carved;
  logic [12:0] cfg_block_bytes;
  logic [8:0]  cfg_blocks_in_use;

  rsp_t expected_rsp [$];
  int   live_heads [$];
  int   errors, n_sent, n_checked, n_noblk, n_empty, n_bad;
  bit   tx_idle_en, rx_idle_en;
  int   rx_hold;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #100ms;
    $display("timeout at %0t", $time);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int eff_bytes();
    if (cfg_block_bytes == 0) return 1;
    if (cfg_block_bytes > lbbm_pkg::MAX_BLOCK_BYTES) return lbbm_pkg::MAX_BLOCK_BYTES;
    return cfg_block_bytes;
  endfunction

  // follows links from start; returns last block visited
  function automatic int chain_walk(input int start, input bit stop_on_last,
                                    output int cnt, output longint sum, output bit known);
    int node;
    node  = start;
    cnt   = 1;
    sum   = size_tbl[node];
    known = size_known[node];
    while (cnt < lbbm_pkg::NUM_BLOCKS) begin
      if (stop_on_last && last_tbl[node]) break;
      if (nxt_tbl[node] >= lbbm_pkg::NULL_LINK) break;
      node = nxt_tbl[node];
      cnt++;
      sum += size_tbl[node];
      known &= size_known[node];
    end
    return node;
  endfunction

  function automatic int take_block();
    int node;
    node = free_head;
    free_head = nxt_tbl[node];
    if (free_cnt > 0) free_cnt--;
    nxt_tbl[node] = lbbm_pkg::NULL_LINK;
    size_tbl[node] = eff_bytes();
    size_known[node] = 1'b1;
    last_tbl[node] = 1'b1;
    if (free_cnt < low_water) low_water = free_cnt;
    return node;
  endfunction

  function automatic rsp_t pool_step(input req_t it);
    rsp_t   r;
    int     cnt, tl, need, got, p, hd, prev, node, n;
    longint sum;
    bit     known;
    r = '0;
    if ((it.operation inside {lbbm_pkg::OP_FREE, lbbm_pkg::OP_LINK, lbbm_pkg::OP_MARK,
                              lbbm_pkg::OP_QUERY, lbbm_pkg::OP_PUSH}
         && it.block >= carved)
        || (it.operation == lbbm_pkg::OP_LINK && it.other_block >= carved)) begin
      r.status = lbbm_pkg::ST_BADIDX;
    end else begin
      case (it.operation)
        lbbm_pkg::OP_INIT: begin
          n = (cfg_blocks_in_use > lbbm_pkg::POOL_MAX) ? lbbm_pkg::POOL_MAX
                                                       : cfg_blocks_in_use;
          for (int i = 0; i < lbbm_pkg::NUM_BLOCKS; i++) begin
            nxt_tbl[i] = (i + 1 < n) ? i + 1 : lbbm_pkg::NULL_LINK;
            last_tbl[i] = 1'b0;
          end
          free_head = (n > 0) ? 0 : lbbm_pkg::NULL_LINK;
          free_cnt = n;
          low_water = n;
          fifo_head = lbbm_pkg::NULL_LINK;
          fifo_tail = lbbm_pkg::NULL_LINK;
          carved = n;
        end
        lbbm_pkg::OP_ALLOC: begin
          need = (it.amount <= eff_bytes()) ? 1 : (it.amount + eff_bytes() - 1) / eff_bytes();
          p = free_head;
          got = 0;
          if (need <= free_cnt)
            while (got < need && p < lbbm_pkg::NUM_BLOCKS) begin
              p = nxt_tbl[p];
              got++;
            end
          if (got < need) begin
            r.status = lbbm_pkg::ST_NOBLK;
            low_water = 0;
          end else begin
            hd = take_block();
            prev = hd;
            for (int i = 1; i < need && free_head < lbbm_pkg::NUM_BLOCKS; i++) begin
              node = take_block();
              last_tbl[prev] = 1'b0;
              nxt_tbl[prev] = node;
              prev = node;
            end
            r.result_block = hd;
          end
        end
        lbbm_pkg::OP_FREE: begin
          tl = chain_walk(it.block, 1'b0, cnt, sum, known);
          nxt_tbl[tl] = free_head;
          free_head = it.block;
          free_cnt = (free_cnt + cnt > lbbm_pkg::POOL_MAX) ? lbbm_pkg::POOL_MAX
                                                           : free_cnt + cnt;
        end
        lbbm_pkg::OP_LINK: begin
          tl = chain_walk(it.block, 1'b0, cnt, sum, known);
          last_tbl[tl] = 1'b0;
          last_tbl[it.other_block] = 1'b1;
          nxt_tbl[tl] = it.other_block;
        end
        lbbm_pkg::OP_MARK: begin
          if (it.amount < size_tbl[it.block]) size_tbl[it.block] = it.amount;
        end
        lbbm_pkg::OP_QUERY: begin
          tl = chain_walk(it.block, 1'b1, cnt, sum, known);
          r.used_bytes = (sum > lbbm_pkg::BYTES_MAX) ? lbbm_pkg::BYTES_MAX : sum;
          sum = longint'(cnt) * eff_bytes();
          r.chain_bytes = (sum > lbbm_pkg::BYTES_MAX) ? lbbm_pkg::BYTES_MAX : sum;
        end
        lbbm_pkg::OP_PUSH: begin
          if (fifo_head >= lbbm_pkg::NULL_LINK) fifo_head = it.block;
          else if (fifo_tail < lbbm_pkg::NULL_LINK) nxt_tbl[fifo_tail] = it.block;
          fifo_tail = chain_walk(it.block, 1'b0, cnt, sum, known);
        end
        default: begin
          if (fifo_head >= lbbm_pkg::NULL_LINK) begin
            r.status = lbbm_pkg::ST_EMPTY;
          end else begin
            r.result_block = fifo_head;
            tl = chain_walk(fifo_head, 1'b1, cnt, sum, known);
            fifo_head = nxt_tbl[tl];
            if (fifo_head >= lbbm_pkg::NULL_LINK) begin
              fifo_head = lbbm_pkg::NULL_LINK;
              fifo_tail = lbbm_pkg::NULL_LINK;
            end
            nxt_tbl[tl] = lbbm_pkg::NULL_LINK;
          end
        end
      endcase
    end
    r.free_now = free_cnt;
    r.free_min = low_water;
    return r;
  endfunction

  // true when the request would read a used size never written
  function automatic bit reads_unknown(input req_t it);
    int     cnt;
    longint sum;
    bit     known;
    if (it.block >= carved) return 1'b0;
    if (it.operation == lbbm_pkg::OP_MARK) return !size_known[it.block];
    if (it.operation == lbbm_pkg::OP_QUERY) begin
      void'(chain_walk(it.block, 1'b1, cnt, sum, known));
      return !known;
    end
    return 1'b0;
  endfunction

  function automatic int pick_block();
    int k;
    if (live_heads.size() > 0 && $urandom_range(0, 9) < 8) begin
      k = $urandom_range(0, live_heads.size() - 1);
      return live_heads[k];
    end
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
    return $urandom_range(0, (carved > 0) ? carved - 1 : 3);
  endfunction

  function automatic void drop_head(input int b);
    foreach (live_heads[i])
      if (live_heads[i] == b) begin
        live_heads.delete(i);
        return;
      end
  endfunction

  function automatic req_t random_req();
    req_t it;
    int   w;
    it = '0;
    w = $urandom_range(0, 99);
    if (w < 2)       it.operation = lbbm_pkg::OP_INIT;
    else if (w < 30) it.operation = lbbm_pkg::OP_ALLOC;
    else if (w < 42) it.operation = lbbm_pkg::OP_FREE;
    else if (w < 50) it.operation = lbbm_pkg::OP_LINK;
    else if (w < 60) it.operation = lbbm_pkg::OP_MARK;
    else if (w < 74) it.operation = lbbm_pkg::OP_QUERY;
    else if (w < 87) it.operation = lbbm_pkg::OP_PUSH;
    else             it.operation = lbbm_pkg::OP_POP;
    it.block = pick_block();
    it.other_block = pick_block();
    if ($urandom_range(0, 15) == 0) it.amount = $urandom;
    else it.amount = $urandom_range(0, eff_bytes() * 4);
    if (reads_unknown(it)) it.operation = lbbm_pkg::OP_POP;
    return it;
  endfunction

  // caller is just past a falling edge and returns just past one
  task automatic send_item(input req_t it);
    rsp_t r;
    req.operation = it.operation;
    req.block = it.block;
    req.other_block = it.other_block;
    req.amount = it.amount;
    req.valid = 1'b1;
    do @(posedge clk_i); while (!req.ready);
    r = pool_step(it);
    expected_rsp.push_back(r);
    n_sent++;
    case (r.status)
      lbbm_pkg::ST_NOBLK:  n_noblk++;
      lbbm_pkg::ST_EMPTY:  n_empty++;
      lbbm_pkg::ST_BADIDX: n_bad++;
      default: ;
    endcase
    if (r.status == lbbm_pkg::ST_OK) begin
      if (it.operation == lbbm_pkg::OP_ALLOC || it.operation == lbbm_pkg::OP_POP)
        live_heads.push_back(r.result_block);
      if (it.operation == lbbm_pkg::OP_FREE || it.operation == lbbm_pkg::OP_PUSH)
        drop_head(it.block);
      if (it.operation == lbbm_pkg::OP_LINK) drop_head(it.other_block);
      if (it.operation == lbbm_pkg::OP_INIT) live_heads.delete();
    end
    @(negedge clk_i);
    req.valid = 1'b0;
    if (tx_idle_en && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
  endtask

  task automatic send_op(input logic [2:0] op, input int blk, input int oth, input int amt);
    req_t it;
    it.operation = op;
    it.block = blk;
    it.other_block = oth;
    it.amount = amt;
    send_item(it);
  endtask

  task automatic drain();
    while (expected_rsp.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    apb.psel = 1'b1;
    apb.pwrite = 1'b1;
    apb.paddr = addr;
    apb.pwdata = data;
    @(negedge clk_i);
    apb.penable = 1'b1;
    @(negedge clk_i);
    apb.psel = 1'b0;
    apb.penable = 1'b0;
    apb.pwrite = 1'b0;
    if (addr == {lbbm_pkg::REG_BLOCK_BYTES, 2'b00}) cfg_block_bytes = data[12:0];
    else cfg_blocks_in_use = data[8:0];
  endtask

  task automatic set_config(input int bb, input int biu);
    drain();
    reg_write({lbbm_pkg::REG_BLOCK_BYTES, 2'b00}, bb);
    reg_write({lbbm_pkg::REG_BLOCKS_IN_USE, 2'b00}, biu);
  endtask

  // response checker
  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (expected_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected response beat, expected none, got status %0d",
                 $time, rsp.status);
      end else begin
        e = expected_rsp.pop_front();
        n_checked++;
        check_field("status", e.status, rsp.status);
        check_field("result_block", e.result_block, rsp.result_block);
        check_field("used_bytes", e.used_bytes, rsp.used_bytes);
        check_field("chain_bytes", e.chain_bytes, rsp.chain_bytes);
        check_field("free_now", e.free_now, rsp.free_now);
        check_field("free_min", e.free_min, rsp.free_min);
      end
    end
  end

  // response side stalls
  initial begin
    int burst;
    burst = 0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        rsp.ready = 1'b0;
        rx_hold--;
      end else if (burst > 0) begin
        burst--;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        rsp.ready = 1'b0;
        burst = $urandom_range(0, 14);
      end else begin
        rsp.ready = 1'b1;
      end
    end
  end

  task automatic test_before_init();
    send_op(lbbm_pkg::OP_POP, 0, 0, 0);
    send_op(lbbm_pkg::OP_QUERY, 0, 0, 0);
    send_op(lbbm_pkg::OP_ALLOC, 0, 0, 1);
    send_op(lbbm_pkg::OP_LINK, 255, 255, 0);
  endtask

  task automatic test_directed_ops();
    send_op(lbbm_pkg::OP_INIT, 0, 0, 0);
    send_op(lbbm_pkg::OP_ALLOC, 0, 0, 0);           // zero bytes still takes a block
    send_op(lbbm_pkg::OP_ALLOC, 0, 0, 64);
    send_op(lbbm_pkg::OP_ALLOC, 0, 0, 65);          // two blocks
    send_op(lbbm_pkg::OP_MARK, 2, 0, 10);
    send_op(lbbm_pkg::OP_MARK, 3, 0, 1000);         // larger than current size: no change
    send_op(lbbm_pkg::OP_QUERY, 2, 0, 0);
    send_op(lbbm_pkg::OP_LINK, 0, 1, 0);
    send_op(lbbm_pkg::OP_QUERY, 0, 0, 0);
    send_op(lbbm_pkg::OP_PUSH, 0, 0, 0);
    send_op(lbbm_pkg::OP_PUSH, 2, 0, 0);
    send_op(lbbm_pkg::OP_POP, 0, 0, 0);
    send_op(lbbm_pkg::OP_POP, 0, 0, 0);
    send_op(lbbm_pkg::OP_POP, 0, 0, 0);
    send_op(lbbm_pkg::OP_POP, 0, 0, 0);             // empty fifo
    send_op(lbbm_pkg::OP_FREE, 2, 0, 0);
    send_op(lbbm_pkg::OP_ALLOC, 0, 0, 21'h1FFFFF);  // out of blocks, low water drops
    send_op(lbbm_pkg::OP_ALLOC, 0, 0, 64 * 250);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_item(random_req());
  endtask

  task automatic test_config_extremes();
    set_config(0, 1);                     // zero size acts as one byte
    send_op(lbbm_pkg::OP_INIT, 0, 0, 0);
    send_op(lbbm_pkg::OP_ALLOC, 0, 0, 0);
    send_op(lbbm_pkg::OP_ALLOC, 0, 0, 2);
    send_op(lbbm_pkg::OP_FREE, 200, 0, 0); // bad index beyond single carved block
    set_config(13'h1FFF, 0);              // saturates at max, no blocks carved
    send_op(lbbm_pkg::OP_INIT, 0, 0, 0);
    send_op(lbbm_pkg::OP_ALLOC, 0, 0, 5);
    send_op(lbbm_pkg::OP_MARK, 0, 0, 0);
    set_config(4096, 9'h1FF);             // saturates to full pool
    send_op(lbbm_pkg::OP_INIT, 0, 0, 0);
    run_random(30);
    set_config(1, 256);
    send_op(lbbm_pkg::OP_INIT, 0, 0, 0);
    run_random(40);
    set_config(37, 12);
    send_op(lbbm_pkg::OP_INIT, 0, 0, 0);
    run_random(40);
  endtask

  task automatic test_backpressure();
    set_config(64, 256);
    send_op(lbbm_pkg::OP_INIT, 0, 0, 0);
    rx_hold = 300;
    run_random(20);
    drain();
    run_random(20);
  endtask

  task automatic test_random_mixed();
    set_config(48, 200);
    send_op(lbbm_pkg::OP_INIT, 0, 0, 0);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    run_random(250);
    set_config($urandom_range(1, 4096), $urandom_range(1, 256));
    send_op(lbbm_pkg::OP_INIT, 0, 0, 0);
    run_random(200);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_random(100);
  endtask

  initial begin
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_noblk = 0;
    n_empty = 0;
    n_bad = 0;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    rx_hold = 0;
    req.valid = 1'b0;
    req.operation = lbbm_pkg::OP_INIT;
    req.block = '0;
    req.other_block = '0;
    req.amount = '0;
    apb.psel = 1'b0;
    apb.penable = 1'b0;
    apb.pwrite = 1'b0;
    apb.paddr = '0;
    apb.pwdata = '0;
    for (int i = 0; i < lbbm_pkg::NUM_BLOCKS; i++) begin
      nxt_tbl[i] = lbbm_pkg::NULL_LINK;
      last_tbl[i] = 1'b0;
      size_tbl[i] = '0;
      size_known[i] = 1'b0;
    end
    free_head = lbbm_pkg::NULL_LINK;
    free_cnt = '0;
    low_water = '0;
    fifo_head = lbbm_pkg::NULL_LINK;
    fifo_tail = lbbm_pkg::NULL_LINK;
    carved = '0;
    cfg_block_bytes = lbbm_pkg::BLOCK_BYTES_RST;
    cfg_blocks_in_use = lbbm_pkg::BLOCKS_IN_USE_RST;
    rst_ni = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_before_init();
    test_directed_ops();
    test_config_extremes();
    test_backpressure();
    test_random_mixed();

    drain();
    $display("covered %0d requests, %0d responses checked", n_sent, n_checked);
    $display("out-of-blocks %0d, empty-fifo pops %0d, bad-index %0d",
             n_noblk, n_empty, n_bad);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
